// ===== rtl/kmm_pkg.sv =====
// Shared types and constants for the knob menu mode controller.
package kmm_pkg;

  localparam int HueW    = 9;
  localparam int PctW    = 7;
  localparam int DeltaW  = 7;
  localparam int AdjustW = 19;
  localparam int ModeW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 9;

  // Output encoding of the display mode.
  localparam logic [ModeW-1:0] CODE_WORD    = 3'd0;
  localparam logic [ModeW-1:0] CODE_DIGITAL = 3'd1;
  localparam logic [ModeW-1:0] CODE_HUE     = 3'd2;
  localparam logic [ModeW-1:0] CODE_SAT     = 3'd3;
  localparam logic [ModeW-1:0] CODE_HOUR    = 3'd4;
  localparam logic [ModeW-1:0] CODE_MINUTE  = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_START_HUE        = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_SATURATION = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_START_BRIGHTNESS = 2'd2;

  // Reset values of the working color.
  localparam logic [HueW-1:0] RESET_HUE        = 9'd0;
  localparam logic [PctW-1:0] RESET_SATURATION = 7'd100;
  localparam logic [PctW-1:0] RESET_BRIGHTNESS = 7'd50;

  localparam int PctMin     = 5;
  localparam int PctMax     = 100;
  localparam int HueFull    = 360;
  localparam int SecPerHour = 3600;
  localparam int SecPerMin  = 60;

  typedef enum logic [5:0] {
    MODE_WORD    = 6'b000001,
    MODE_DIGITAL = 6'b000010,
    MODE_HUE     = 6'b000100,
    MODE_SAT     = 6'b001000,
    MODE_HOUR    = 6'b010000,
    MODE_MINUTE  = 6'b100000
  } mode_t;

endpackage

// ===== rtl/knob_menu_mode_controller.sv =====
// Top level of the knob menu mode controller: mode state machine, color update, result register.
// A result shows on the output in the cycle after its input transfer.
// Throughput: one item per cycle; the only limit is the single result register,
// so an input transfer is refused only while a held result is stalled.
// Reset (rst, synchronous, active high) returns to word mode with hue 0,
// saturation 100 and brightness 50, and empties the result register.
module knob_menu_mode_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  logic [kmm_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [kmm_pkg::CfgW-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              short_press,
  input  logic                              long_press,
  input  logic signed [kmm_pkg::DeltaW-1:0] knob_delta,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kmm_pkg::ModeW-1:0]         mode,
  output logic [kmm_pkg::HueW-1:0]          hue,
  output logic [kmm_pkg::PctW-1:0]          saturation,
  output logic [kmm_pkg::PctW-1:0]          brightness,
  output logic signed [kmm_pkg::AdjustW-1:0] time_adjust_seconds,
  output logic                              enter_edit,
  output logic                              exit_edit
);
  import kmm_pkg::*;

  // Working state. The start registers are never read back, so a
  // configuration write goes straight into the working color.
  mode_t           mode_reg;
  logic [HueW-1:0] hue_reg;
  logic [PctW-1:0] saturation_reg;
  logic [PctW-1:0] brightness_reg;

  mode_t                     mode_pressed;
  mode_t                     mode_next;
  logic                      enter_next;
  logic                      exit_next;
  logic [HueW-1:0]           hue_next;
  logic [PctW-1:0]           saturation_next;
  logic [PctW-1:0]           brightness_next;
  logic signed [AdjustW-1:0] adjust_next;
  logic [ModeW-1:0]          code_next;
  logic                      in_xfer;
  logic                      turned;

  // Sign-extended knob deltas and the adjusted values.
  logic signed [9:0]         pct_step;
  logic signed [10:0]        delta11;
  logic signed [10:0]        hue_sum;
  logic signed [9:0]         sat_sum;
  logic signed [9:0]         bright_sum;
  logic signed [AdjustW-1:0] delta19;
  logic [HueW-1:0]           hue_wrapped;
  logic [PctW-1:0]           sat_clamped;
  logic [PctW-1:0]           bright_clamped;

  // A new item is refused only while the held result is waiting on the
  // downstream side; otherwise the result register frees up this cycle.
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign turned   = (knob_delta != '0);

  // Short press acts first: it steps through the display modes, and in the
  // edit modes it swaps between setting the hour and the minute.
  always_comb begin
    unique case (mode_reg)
      MODE_WORD:    mode_pressed = short_press ? MODE_DIGITAL : MODE_WORD;
      MODE_DIGITAL: mode_pressed = short_press ? MODE_HUE     : MODE_DIGITAL;
      MODE_HUE:     mode_pressed = short_press ? MODE_SAT     : MODE_HUE;
      MODE_SAT:     mode_pressed = short_press ? MODE_WORD    : MODE_SAT;
      MODE_HOUR:    mode_pressed = short_press ? MODE_MINUTE  : MODE_HOUR;
      MODE_MINUTE:  mode_pressed = short_press ? MODE_HOUR    : MODE_MINUTE;
      default:      mode_pressed = MODE_WORD;
    endcase
  end

  // Long press then enters minute edit from any display mode, or leaves
  // edit back to word mode.
  always_comb begin
    mode_next  = mode_pressed;
    enter_next = 1'b0;
    exit_next  = 1'b0;
    if (long_press) begin
      if (mode_pressed == MODE_HOUR || mode_pressed == MODE_MINUTE) begin
        mode_next = MODE_WORD;
        exit_next = 1'b1;
      end else begin
        mode_next  = MODE_MINUTE;
        enter_next = 1'b1;
      end
    end
  end

  // Knob arithmetic. Percent values move two per detent and clamp to 5..100;
  // hue moves five per detent and wraps into 1..360, so zero shows as 360.
  // Stored values may be out of range after a configuration write, which is
  // why the hue sum can need two subtractions of 360 to come back into range.
  assign pct_step   = 10'(signed'({knob_delta, 1'b0}));
  assign delta11    = 11'(knob_delta);
  assign hue_sum    = signed'({2'b00, hue_reg}) + (delta11 <<< 2) + delta11;
  assign sat_sum    = signed'({3'b000, saturation_reg}) + pct_step;
  assign bright_sum = signed'({3'b000, brightness_reg}) + pct_step;
  assign delta19    = AdjustW'(knob_delta);

  always_comb begin
    if (hue_sum <= 11'sd0) begin
      hue_wrapped = HueW'(hue_sum + 11'(HueFull));
    end else if (hue_sum > 11'(2 * HueFull)) begin
      hue_wrapped = HueW'(hue_sum - 11'(2 * HueFull));
    end else if (hue_sum > 11'(HueFull)) begin
      hue_wrapped = HueW'(hue_sum - 11'(HueFull));
    end else begin
      hue_wrapped = HueW'(hue_sum);
    end
  end

  always_comb begin
    if (sat_sum < 10'(PctMin)) begin
      sat_clamped = PctW'(PctMin);
    end else if (sat_sum > 10'(PctMax)) begin
      sat_clamped = PctW'(PctMax);
    end else begin
      sat_clamped = PctW'(sat_sum);
    end
    if (bright_sum < 10'(PctMin)) begin
      bright_clamped = PctW'(PctMin);
    end else if (bright_sum > 10'(PctMax)) begin
      bright_clamped = PctW'(PctMax);
    end else begin
      bright_clamped = PctW'(bright_sum);
    end
  end

  // The knob acts in the mode left after both presses.
  always_comb begin
    hue_next        = hue_reg;
    saturation_next = saturation_reg;
    brightness_next = brightness_reg;
    adjust_next     = '0;
    if (turned) begin
      unique case (mode_next) inside
        MODE_WORD, MODE_DIGITAL: brightness_next = bright_clamped;
        MODE_HUE:                hue_next        = hue_wrapped;
        MODE_SAT:                saturation_next = sat_clamped;
        MODE_HOUR:               adjust_next     = delta19 * AdjustW'(SecPerHour);
        MODE_MINUTE:             adjust_next     = delta19 * AdjustW'(SecPerMin);
        default:                 adjust_next     = '0;
      endcase
    end
  end

  always_comb begin
    unique case (mode_next)
      MODE_WORD:    code_next = CODE_WORD;
      MODE_DIGITAL: code_next = CODE_DIGITAL;
      MODE_HUE:     code_next = CODE_HUE;
      MODE_SAT:     code_next = CODE_SAT;
      MODE_HOUR:    code_next = CODE_HOUR;
      MODE_MINUTE:  code_next = CODE_MINUTE;
      default:      code_next = CODE_WORD;
    endcase
  end

  // State update. The user must give configuration writes only while the block is idle,
  // so they never meet an item transfer in the same cycle; the block itself has no guard for this.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_WORD;
      hue_reg        <= RESET_HUE;
      saturation_reg <= RESET_SATURATION;
      brightness_reg <= RESET_BRIGHTNESS;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_START_HUE:        hue_reg        <= cfg_data;
        REG_START_SATURATION: saturation_reg <= cfg_data[PctW-1:0];
        REG_START_BRIGHTNESS: brightness_reg <= cfg_data[PctW-1:0];
        default:              ;
      endcase
    end else if (in_xfer) begin
      mode_reg       <= mode_next;
      hue_reg        <= hue_next;
      saturation_reg <= saturation_next;
      brightness_reg <= brightness_next;
    end
  end

  // Result register: loads on every input transfer, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode                <= code_next;
      hue                 <= hue_next;
      saturation          <= saturation_next;
      brightness          <= brightness_next;
      time_adjust_seconds <= adjust_next;
      enter_edit          <= enter_next;
      exit_edit           <= exit_next;
    end
  end

endmodule

// ===== rtl/kmm_checker.sv =====
// Port-level checker for the knob menu mode controller and its bind.
module kmm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [kmm_pkg::ModeW-1:0]         mode,
  input logic signed [kmm_pkg::AdjustW-1:0] time_adjust_seconds,
  input logic                              enter_edit,
  input logic                              exit_edit
);
  import kmm_pkg::*;

  // Every input transfer leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("input transfer produced no result");

  // A stalled result stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode) && $stable(time_adjust_seconds))
    else $error("stalled result changed");

  // Entering edit always lands in minute edit; leaving always lands in word mode.
  a_enter_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && enter_edit |-> mode == CODE_MINUTE && !exit_edit)
    else $error("enter_edit without minute mode");

  a_exit_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && exit_edit |-> mode == CODE_WORD && time_adjust_seconds == '0)
    else $error("exit_edit without word mode");

  // A time adjustment only comes out of an edit mode.
  a_adjust_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_adjust_seconds != '0 |-> mode == CODE_HOUR || mode == CODE_MINUTE)
    else $error("time adjustment outside edit mode");

endmodule

bind knob_menu_mode_controller kmm_checker u_kmm_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .mode                (mode),
  .time_adjust_seconds (time_adjust_seconds),
  .enter_edit          (enter_edit),
  .exit_edit           (exit_edit)
);

// ===== dv/knob_menu_mode_controller_tb.sv =====
// Self-checking testbench for the knob menu mode controller.
module knob_menu_mode_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmm_pkg::*;

  // The block has three start registers; index 3 is decoded as nothing and
  // must leave the working color alone.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  // Knob gains per detent, as the front panel defines them.
  localparam int PCT_STEP = 2;
  localparam int HUE_STEP = 5;

  localparam logic signed [DeltaW-1:0] DELTA_MAX = DeltaW'(63);
  localparam logic signed [DeltaW-1:0] DELTA_MIN = DeltaW'(-64);

  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 3;    // result shows in the cycle after its transfer
  localparam int DRAIN_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int REPORT_LIMIT    = 10;
  localparam int PHASES          = 9;
  localparam int PHASE_ITEMS     = 40;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  // One expected panel update, at the widths of the result ports.
  typedef struct {
    logic [ModeW-1:0]          mode;
    logic [HueW-1:0]           hue;
    logic [PctW-1:0]           sat;
    logic [PctW-1:0]           bright;
    logic signed [AdjustW-1:0] adjust;
    logic                      enter;
    logic                      leave;
  } panel_t;

  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      cfg_en      = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index   = '0;
  logic [CfgW-1:0]           cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      short_press = 1'b0;
  logic                      long_press  = 1'b0;
  logic signed [DeltaW-1:0]  knob_delta  = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [ModeW-1:0]          mode;
  logic [HueW-1:0]           hue;
  logic [PctW-1:0]           saturation;
  logic [PctW-1:0]           brightness;
  logic signed [AdjustW-1:0] time_adjust_seconds;
  logic                      enter_edit;
  logic                      exit_edit;

  knob_menu_mode_controller dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_en              (cfg_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .short_press         (short_press),
    .long_press          (long_press),
    .knob_delta          (knob_delta),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .mode                (mode),
    .hue                 (hue),
    .saturation          (saturation),
    .brightness          (brightness),
    .time_adjust_seconds (time_adjust_seconds),
    .enter_edit          (enter_edit),
    .exit_edit           (exit_edit)
  );

  // Our own copy of the panel state. It moves forward at every accepted input
  // transfer and is reloaded by every start register write.
  logic [ModeW-1:0] ui_mode    = CODE_WORD;
  int               hue_now    = int'(RESET_HUE);
  int               sat_now    = int'(RESET_SATURATION);
  int               bright_now = int'(RESET_BRIGHTNESS);

  // Panel updates predicted but not yet seen on the result port, oldest first.
  panel_t expected_panel_q[$];
  int     mismatch_count = 0;

  // Sender idling: bursts of random length separated by random gaps.
  bit sender_gaps = 1'b1;
  int burst_left  = 0;

  // Receiver idling. A test asks for a long hold-off by bumping the request
  // count; the receiver process serves it and counts the cycles itself.
  stall_style_t stall_style       = STALL_LIGHT;
  int           hold_off_requests = 0;
  int           hold_off_served   = 0;
  int           hold_left         = 0;
  int           stall_phase       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous wall for the whole run: a correct run needs well under a tenth of it.
  initial begin
    #2_000_000;
    $display("knob_menu_mode_controller_tb failed");
    $finish;
  end

  function automatic int clamp_pct(input int v);
    if (v < PctMin) return PctMin;
    if (v > PctMax) return PctMax;
    return v;
  endfunction

  // Apply one input transfer to the panel state: short press, then long press,
  // then the knob in whatever mode the presses left behind.
  task automatic predict_panel(input logic sp, input logic lp,
                               input logic signed [DeltaW-1:0] d, output panel_t r);
    int turn;
    turn     = int'(d);
    r.adjust = '0;
    r.enter  = 1'b0;
    r.leave  = 1'b0;
    if (sp) begin
      case (ui_mode)
        CODE_WORD:    ui_mode = CODE_DIGITAL;
        CODE_DIGITAL: ui_mode = CODE_HUE;
        CODE_HUE:     ui_mode = CODE_SAT;
        CODE_HOUR:    ui_mode = CODE_MINUTE;
        CODE_MINUTE:  ui_mode = CODE_HOUR;
        default:      ui_mode = CODE_WORD;
      endcase
    end
    if (lp) begin
      if (ui_mode <= CODE_SAT) begin
        r.enter = 1'b1;
        ui_mode = CODE_MINUTE;
      end else begin
        r.leave = 1'b1;
        ui_mode = CODE_WORD;
      end
    end
    if (turn != 0) begin
      case (ui_mode) inside
        CODE_WORD, CODE_DIGITAL: bright_now = clamp_pct(bright_now + PCT_STEP * turn);
        CODE_SAT:                sat_now    = clamp_pct(sat_now + PCT_STEP * turn);
        CODE_HUE: begin
          // Hue lives in 1..360, so landing on zero shows as 360.
          hue_now = hue_now + HUE_STEP * turn;
          while (hue_now <= 0) hue_now += HueFull;
          while (hue_now > HueFull) hue_now -= HueFull;
        end
        CODE_HOUR:   r.adjust = AdjustW'(turn * SecPerHour);
        CODE_MINUTE: r.adjust = AdjustW'(turn * SecPerMin);
        default: ;
      endcase
    end
    r.mode   = ui_mode;
    r.hue    = hue_now[HueW-1:0];
    r.sat    = sat_now[PctW-1:0];
    r.bright = bright_now[PctW-1:0];
  endtask

  // Offer one item and hold it until the block takes it. The expectation is
  // queued at the very edge of the transfer, so the queue order is the
  // order in which items went in.
  task automatic send_knob_event(input logic sp, input logic lp,
                                 input logic signed [DeltaW-1:0] d);
    panel_t want;
    int     gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid    <= 1'b1;
    short_press <= sp;
    long_press  <= lp;
    knob_delta  <= d;
    do @(posedge clk); while (in_stall);
    predict_panel(sp, lp, d, want);
    expected_panel_q.push_back(want);
    if (burst_left > 0) burst_left--;
  endtask

  // Stop offering items and wait until every predicted result has come out.
  // The bound only keeps a hung block from stalling the end of the run.
  task automatic drain_results();
    int waited;
    waited = 0;
    if (in_valid) in_valid <= 1'b0;
    while (expected_panel_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Start register write. Only called with nothing in flight, after drain_results
  // and any earlier writes, so the working color it loads is what the next item sees.
  task automatic write_start_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_START_HUE:        hue_now    = int'(data);
      REG_START_SATURATION: sat_now    = int'(data[PctW-1:0]);
      REG_START_BRIGHTNESS: bright_now = int'(data[PctW-1:0]);
      default: ;
    endcase
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  // Walk the menu to a given mode with plain presses and no knob turns.
  task automatic goto_mode(input logic [ModeW-1:0] target);
    while (ui_mode != target) begin
      if ((target >= CODE_HOUR) == (ui_mode >= CODE_HOUR)) send_knob_event(1'b1, 1'b0, '0);
      else send_knob_event(1'b0, 1'b1, '0);
    end
  endtask

  task automatic send_random_event();
    logic                     sp;
    logic                     lp;
    logic signed [DeltaW-1:0] d;
    int                       roll;
    sp   = ($urandom_range(0, 99) < 30);
    lp   = ($urandom_range(0, 99) < 12);
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      d = '0;
    end else if (roll < 60) begin
      d = DeltaW'($urandom_range(1, 4));
      if ($urandom_range(0, 1)) d = -d;
    end else if (roll < 70) begin
      d = $urandom_range(0, 1) ? DELTA_MAX : DELTA_MIN;
    end else begin
      d = DeltaW'($urandom_range(0, 127));
    end
    send_knob_event(sp, lp, d);
  endtask

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Result checker: every transfer on the result port is compared, field by
  // field, with the oldest pending expectation.
  always @(posedge clk) begin : check_results
    panel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_panel_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result transfer with no pending expectation", $time);
      end else begin
        want = expected_panel_q.pop_front();
        check_field("mode", 32'(want.mode), 32'(mode));
        check_field("hue", 32'(want.hue), 32'(hue));
        check_field("saturation", 32'(want.sat), 32'(saturation));
        check_field("brightness", 32'(want.bright), 32'(brightness));
        check_field("time_adjust_seconds", 32'(want.adjust), 32'(time_adjust_seconds));
        check_field("enter_edit", 32'(want.enter), 32'(enter_edit));
        check_field("exit_edit", 32'(want.leave), 32'(exit_edit));
      end
    end
  end

  // Receiver. A pending hold-off request wins over the current stall style.
  always @(posedge clk) begin
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_left       = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 65);
        STALL_PERIODIC: begin
          stall_phase = (stall_phase + 1) % 7;
          out_stall <= (stall_phase < 3);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Clamping of brightness and saturation at both ends, and the hue wrap in
  // both directions, including the case where the sum lands exactly on zero.
  task automatic test_knob_limits();
    send_knob_event(1'b0, 1'b0, '0);         // reset values as they stand
    send_knob_event(1'b0, 1'b0, DELTA_MAX);  // brightness clamps at the top
    send_knob_event(1'b0, 1'b0, DELTA_MIN);  // and at the bottom
    send_knob_event(1'b1, 1'b0, '0);         // into digital mode
    send_knob_event(1'b0, 1'b0, 7'sd1);
    send_knob_event(1'b1, 1'b0, 7'sd1);      // into hue mode, hue goes to 5
    send_knob_event(1'b0, 1'b0, -7'sd1);     // hue reaches zero and shows as 360
    send_knob_event(1'b0, 1'b0, DELTA_MAX);  // wraps down past 360
    send_knob_event(1'b0, 1'b0, DELTA_MIN);  // wraps up past zero
    send_knob_event(1'b1, 1'b0, DELTA_MIN);  // into saturation mode, clamps low
    send_knob_event(1'b0, 1'b0, DELTA_MAX);  // clamps high
    send_knob_event(1'b1, 1'b0, '0);         // saturation mode wraps to word
  endtask

  // Edit entry and exit, the hour and minute toggle, time adjustment at both
  // knob extremes, and both presses arriving in one item.
  task automatic test_button_modes();
    send_knob_event(1'b0, 1'b1, '0);         // enter edit at minutes
    send_knob_event(1'b0, 1'b0, DELTA_MAX);
    send_knob_event(1'b1, 1'b0, DELTA_MIN);  // toggle to hours, largest step back
    send_knob_event(1'b0, 1'b0, DELTA_MAX);
    send_knob_event(1'b0, 1'b1, '0);         // leave edit
    send_knob_event(1'b1, 1'b1, 7'sd5);      // to digital, then straight into edit
    send_knob_event(1'b1, 1'b1, -7'sd3);     // toggle, then leave; knob hits brightness
    send_knob_event(1'b1, 1'b1, '0);
    send_knob_event(1'b0, 1'b1, '0);
    send_knob_event(1'b1, 1'b0, '0);
    send_knob_event(1'b1, 1'b0, '0);         // now in hue mode
    send_knob_event(1'b0, 1'b1, -7'sd2);     // enter edit from hue, minute step
    send_knob_event(1'b0, 1'b1, 7'sd2);      // leave edit with a brightness turn
  endtask

  // Write one start value with the panel sitting in a mode where the knob
  // moves that value, so an out-of-range value is first shown as written and
  // then pulled back into range by the next turn.
  task automatic try_start_value(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value,
                                 input logic [ModeW-1:0] view);
    logic signed [DeltaW-1:0] d;
    d = DeltaW'($urandom_range(1, 20));
    if ($urandom_range(0, 1)) d = -d;
    goto_mode(view);
    drain_results();
    write_start_reg(idx, value);
    send_knob_event(1'b0, 1'b0, '0);
    send_knob_event(1'b0, 1'b0, d);
  endtask

  // Start registers at their limits (hue only at 360), hue just outside them,
  // bits above a percent register's width set, and the undecoded index.
  task automatic test_start_registers();
    try_start_value(REG_START_HUE, 9'd0, CODE_HUE);
    try_start_value(REG_START_HUE, 9'd360, CODE_HUE);
    try_start_value(REG_START_HUE, 9'd511, CODE_HUE);
    try_start_value(REG_START_HUE, 9'd361, CODE_HUE);
    try_start_value(REG_START_SATURATION, 9'd5, CODE_SAT);
    try_start_value(REG_START_SATURATION, 9'd100, CODE_SAT);
    try_start_value(REG_START_SATURATION, 9'd0, CODE_SAT);
    try_start_value(REG_START_SATURATION, 9'h1FF, CODE_SAT);
    try_start_value(REG_START_BRIGHTNESS, 9'd5, CODE_WORD);
    try_start_value(REG_START_BRIGHTNESS, 9'd100, CODE_DIGITAL);
    try_start_value(REG_START_BRIGHTNESS, 9'h183, CODE_WORD);
    try_start_value(REG_START_BRIGHTNESS, 9'd127, CODE_WORD);
    // The undecoded index must change nothing on the panel.
    drain_results();
    write_start_reg(REG_UNUSED, CfgW'($urandom_range(0, 511)));
    send_knob_event(1'b0, 1'b0, '0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the result register fills and the input stalls. Then
  // the sender waits for every pending result; a second round adds heavy stalls.
  task automatic test_result_backpressure();
    drain_results();
    stall_style = STALL_NONE;
    sender_gaps = 1'b0;
    hold_off_requests++;
    repeat (16) send_random_event();
    drain_results();
    stall_style = STALL_HEAVY;
    hold_off_requests++;
    repeat (16) send_random_event();
    drain_results();
    sender_gaps = 1'b1;
    stall_style = STALL_LIGHT;
  endtask

  // Random traffic in phases. Each phase starts idle with a fresh set of start
  // values (the lowest and highest settings among them) and its own idling;
  // the first phase runs with no idling on either side.
  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        1: begin
          write_start_reg(REG_START_HUE, 9'd0);
          write_start_reg(REG_START_SATURATION, CfgW'(PctMin));
          write_start_reg(REG_START_BRIGHTNESS, CfgW'(PctMin));
        end
        2: begin
          write_start_reg(REG_START_HUE, CfgW'(HueFull));
          write_start_reg(REG_START_SATURATION, CfgW'(PctMax));
          write_start_reg(REG_START_BRIGHTNESS, CfgW'(PctMax));
        end
        default: begin
          // Now and then a value outside the legal range, to be pulled back in.
          write_start_reg(REG_START_HUE, CfgW'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(361, 511) : $urandom_range(1, HueFull)));
          write_start_reg(REG_START_SATURATION, CfgW'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 511) : $urandom_range(PctMin, PctMax)));
          write_start_reg(REG_START_BRIGHTNESS, CfgW'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 511) : $urandom_range(PctMin, PctMax)));
        end
      endcase
      sender_gaps = (phase != 0);
      stall_style = (phase == 0) ? STALL_NONE : stall_style_t'($urandom_range(0, 3));
      repeat (PHASE_ITEMS) send_random_event();
    end
  endtask

  // Reset once, run the tests in turn, then wait for the last results and
  // give the verdict.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_knob_limits();
    test_button_modes();
    test_start_registers();
    test_result_backpressure();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0 && expected_panel_q.size() == 0) begin
      $display("knob_menu_mode_controller_tb passed");
    end else begin
      $display("knob_menu_mode_controller_tb failed");
    end
    $finish;
  end

endmodule
